/* sv/dsp_pkg.sv */
// Shared definitions for the shortest-path search block.
// Holds parameter defaults and the request operation codes; no dependencies.
`default_nettype none

package dsp_pkg;

   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int WEIGHT_BITS_DEFAULT  = 31;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_RUN  = 1'b1
   } op_type;

endpackage

`default_nettype wire

/* sv/dsp_weight_store.sv */
// Adjacency-matrix weight store: one write port for loads, one registered read port.
// Parameters come from dijkstra_shortest_paths; uses no package items.
`default_nettype none

module dsp_weight_store #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 31
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_row,
   input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_col,
   input  wire logic [WEIGHT_BITS-1:0]          wr_data,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_row,
   input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_col,
   output logic      [WEIGHT_BITS-1:0]          rd_data
);

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [WEIGHT_BITS-1:0] mem [DEPTH];
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_in_range;

   assign wr_addr = ADDR_W'(wr_row) * ADDR_W'(MAX_VERTICES) + ADDR_W'(wr_col);
   assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(MAX_VERTICES) + ADDR_W'(rd_col);

   // Loads that name a row or column beyond the matrix are dropped.
   assign wr_in_range = ({1'b0, wr_row} < (VIDX_W + 1)'(MAX_VERTICES)) &&
                        ({1'b0, wr_col} < (VIDX_W + 1)'(MAX_VERTICES));

   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/dsp_search.sv */
// Search sequencer: distance/predecessor memory, visited flags, settle-and-relax
// passes and the result register. Reads dsp_weight_store; uses no package items.
`default_nettype none

module dsp_search #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 31
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [$clog2(MAX_VERTICES)-1:0]   start_src,
   input  wire logic [$clog2(MAX_VERTICES+1)-1:0] start_count,
   output logic                                   idle,
   output logic                                   wt_rd_en,
   output logic      [$clog2(MAX_VERTICES)-1:0]   wt_rd_row,
   output logic      [$clog2(MAX_VERTICES)-1:0]   wt_rd_col,
   input  wire logic [WEIGHT_BITS-1:0]            wt_rd_data,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_valid,
   output logic      [$clog2(MAX_VERTICES)-1:0]   rsp_vertex,
   output logic      [WEIGHT_BITS-1:0]            rsp_dist,
   output logic      [$clog2(MAX_VERTICES)-1:0]   rsp_pred,
   output logic                                   rsp_last
);

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
   localparam int ENTRY_W = WEIGHT_BITS + VIDX_W;
   localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEED,
      S_RELAX,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   state_type               state_ff, state_in;
   logic [VCNT_W-1:0]       n_ff, n_in;
   logic [VIDX_W-1:0]       src_ff, src_in;
   logic [VCNT_W-1:0]       cnt_ff, cnt_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic [VIDX_W-1:0]       s1_k_ff, s1_k_in;
   logic [VIDX_W-1:0]       pick_ff, pick_in;
   logic [WEIGHT_BITS-1:0]  pick_dist_ff, pick_dist_in;
   logic [WEIGHT_BITS-1:0]  best_ff, best_in;
   logic [VIDX_W-1:0]       best_idx_ff, best_idx_in;
   logic                    found_ff, found_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VIDX_W-1:0]       rsp_vertex_ff, rsp_vertex_in;
   logic [WEIGHT_BITS-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [VIDX_W-1:0]       rsp_pred_ff, rsp_pred_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [ENTRY_W-1:0]      dist_mem [MAX_VERTICES];
   logic [ENTRY_W-1:0]      dm_rd_ff;
   logic                    dm_re;
   logic [VIDX_W-1:0]       dm_ra;
   logic                    dm_we;
   logic [VIDX_W-1:0]       dm_wa;
   logic [ENTRY_W-1:0]      dm_wd;

   logic [WEIGHT_BITS-1:0]  cur_dist;
   logic [VIDX_W-1:0]       cur_pred;
   logic [WEIGHT_BITS:0]    path_sum;
   logic [WEIGHT_BITS-1:0]  sat_sum;
   logic [WEIGHT_BITS-1:0]  new_dist;
   logic                    cand;
   logic                    improve;

   assign cur_dist = dm_rd_ff[ENTRY_W-1:VIDX_W];
   assign cur_pred = dm_rd_ff[VIDX_W-1:0];
   assign path_sum = {1'b0, pick_dist_ff} + {1'b0, wt_rd_data};
   assign sat_sum  = (path_sum >= {1'b0, NO_EDGE}) ? NO_EDGE : path_sum[WEIGHT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dist_mem[dm_wa] <= dm_wd;
      end
      if (dm_re) begin
         dm_rd_ff <= dist_mem[dm_ra];
      end
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      src_in        = src_ff;
      cnt_in        = cnt_ff;
      s1_valid_in   = 1'b0;
      s1_k_in       = s1_k_ff;
      pick_in       = pick_ff;
      pick_dist_in  = pick_dist_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      found_in      = found_ff;
      visited_in    = visited_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_pred_in   = rsp_pred_ff;
      rsp_last_in   = rsp_last_ff;
      wt_rd_en      = 1'b0;
      wt_rd_row     = (state_ff == S_SEED) ? src_ff : pick_ff;
      wt_rd_col     = cnt_ff[VIDX_W-1:0];
      dm_re         = 1'b0;
      dm_ra         = cnt_ff[VIDX_W-1:0];
      dm_we         = 1'b0;
      dm_wa         = s1_k_ff;
      dm_wd         = {wt_rd_data, src_ff};
      new_dist      = wt_rd_data;
      cand          = 1'b0;
      improve       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               src_in   = start_src;
               n_in     = start_count;
               cnt_in   = '0;
               best_in  = NO_EDGE;
               found_in = 1'b0;
               state_in = S_SEED;
            end
         end

         S_SEED, S_RELAX: begin
            // Issue side: one vertex column per cycle into both memories.
            if (cnt_ff < n_ff) begin
               wt_rd_en    = 1'b1;
               dm_re       = 1'b1;
               s1_valid_in = 1'b1;
               s1_k_in     = cnt_ff[VIDX_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end

            // Update side: write the new distance and track the next vertex to settle.
            if (s1_valid_ff) begin
               if (state_ff == S_SEED) begin
                  new_dist = (s1_k_ff == src_ff) ? '0 : wt_rd_data;
                  dm_we    = 1'b1;
                  dm_wd    = {new_dist, src_ff};
                  visited_in[s1_k_ff] = (s1_k_ff == src_ff);
                  cand     = (s1_k_ff != src_ff);
               end else begin
                  improve  = !visited_ff[s1_k_ff] && (wt_rd_data != NO_EDGE) &&
                             (sat_sum < cur_dist);
                  new_dist = improve ? sat_sum : cur_dist;
                  dm_we    = improve;
                  dm_wd    = {sat_sum, pick_ff};
                  cand     = !visited_ff[s1_k_ff];
               end
               if (cand && (new_dist < best_ff)) begin
                  best_in     = new_dist;
                  best_idx_in = s1_k_ff;
                  found_in    = 1'b1;
               end
            end

            if ((cnt_ff == n_ff) && !s1_valid_ff) begin
               cnt_in = '0;
               if (found_ff) begin
                  pick_in                 = best_idx_ff;
                  pick_dist_in            = best_ff;
                  visited_in[best_idx_ff] = 1'b1;
                  best_in                 = NO_EDGE;
                  found_in                = 1'b0;
                  state_in                = S_RELAX;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end

         S_EMIT_RD: begin
            dm_re    = 1'b1;
            state_in = S_EMIT_LD;
         end

         S_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = cnt_ff[VIDX_W-1:0];
               rsp_dist_in   = cur_dist;
               rsp_pred_in   = cur_pred;
               rsp_last_in   = (cnt_ff == n_ff - 1'b1);
               if (cnt_ff == n_ff - 1'b1) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         s1_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         n_ff         <= VCNT_W'(1);
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         found_ff     <= found_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
      end
      src_ff        <= src_in;
      s1_k_ff       <= s1_k_in;
      pick_ff       <= pick_in;
      pick_dist_ff  <= pick_dist_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_pred_ff   <= rsp_pred_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_dist   = rsp_dist_ff;
   assign rsp_pred   = rsp_pred_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

/* sv/dijkstra_shortest_paths.sv */
// A load is written into the weight store as it transfers; a run seeds the distances from
// the source row, settles one vertex per settle-and-relax pass, then emits one result per vertex.
// Throughput is set by the single read port of the weight and distance memories.
// Reset clears the sequencer and sets the vertex count to its maximum; the weight
// store is undefined until written and needs no clearing pass.
// Top level: stream ports, vertex-count register; uses dsp_pkg, dsp_weight_store, dsp_search.
`default_nettype none

module dijkstra_shortest_paths #(
   parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEFAULT,
   parameter int WEIGHT_BITS  = dsp_pkg::WEIGHT_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic req_tvalid,
   output logic      req_tready,
   // operation
   input  wire logic req_tuser,
   // row_index, column_index, edge_weight, source_vertex, zero fill
   input  wire logic [((3 * $clog2(MAX_VERTICES) + WEIGHT_BITS + 7) / 8) * 8 - 1:0] req_tdata,

   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // vertex_id, path_distance, predecessor, zero fill
   output logic      [((2 * $clog2(MAX_VERTICES) + WEIGHT_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic      rsp_tlast,

   input  wire logic                              csr_wr_en,
   input  wire logic [$clog2(MAX_VERTICES+1)-1:0] csr_wr_data
);

   localparam int VIDX_W      = $clog2(MAX_VERTICES);
   localparam int VCNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int RSP_BITS    = 2 * VIDX_W + WEIGHT_BITS;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   logic [VCNT_W-1:0]      vertex_count_ff;
   logic [VCNT_W-1:0]      count_eff;
   logic                   req_xfer;
   logic [VIDX_W-1:0]      req_row;
   logic [VIDX_W-1:0]      req_col;
   logic [WEIGHT_BITS-1:0] req_weight;
   logic [VIDX_W-1:0]      req_src;
   logic                   load_en;
   logic                   run_start;
   logic                   search_idle;
   logic                   wt_rd_en;
   logic [VIDX_W-1:0]      wt_rd_row;
   logic [VIDX_W-1:0]      wt_rd_col;
   logic [WEIGHT_BITS-1:0] wt_rd_data;
   logic [VIDX_W-1:0]      out_vertex;
   logic [WEIGHT_BITS-1:0] out_dist;
   logic [VIDX_W-1:0]      out_pred;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCNT_W'(MAX_VERTICES);
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      count_eff = vertex_count_ff;
      if (vertex_count_ff == '0) begin
         count_eff = VCNT_W'(1);
      end else if (vertex_count_ff > VCNT_W'(MAX_VERTICES)) begin
         count_eff = VCNT_W'(MAX_VERTICES);
      end
   end

   assign req_row    = req_tdata[VIDX_W-1:0];
   assign req_col    = req_tdata[2*VIDX_W-1:VIDX_W];
   assign req_weight = req_tdata[2*VIDX_W+WEIGHT_BITS-1:2*VIDX_W];
   assign req_src    = req_tdata[3*VIDX_W+WEIGHT_BITS-1:2*VIDX_W+WEIGHT_BITS];

   assign req_tready = search_idle;
   assign req_xfer   = req_tvalid && req_tready;
   assign load_en    = req_xfer && (dsp_pkg::op_type'(req_tuser) == dsp_pkg::OP_LOAD);
   // A run whose source lies outside the vertices in use is dropped.
   assign run_start  = req_xfer && (dsp_pkg::op_type'(req_tuser) == dsp_pkg::OP_RUN) &&
                       (VCNT_W'(req_src) < count_eff);

   dsp_weight_store #(
      .MAX_VERTICES(MAX_VERTICES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_weight_store (
      .clock  (clock),
      .wr_en  (load_en),
      .wr_row (req_row),
      .wr_col (req_col),
      .wr_data(req_weight),
      .rd_en  (wt_rd_en),
      .rd_row (wt_rd_row),
      .rd_col (wt_rd_col),
      .rd_data(wt_rd_data)
   );

   dsp_search #(
      .MAX_VERTICES(MAX_VERTICES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .start      (run_start),
      .start_src  (req_src),
      .start_count(count_eff),
      .idle       (search_idle),
      .wt_rd_en   (wt_rd_en),
      .wt_rd_row  (wt_rd_row),
      .wt_rd_col  (wt_rd_col),
      .wt_rd_data (wt_rd_data),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_vertex (out_vertex),
      .rsp_dist   (out_dist),
      .rsp_pred   (out_pred),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_TDATA_W'({out_pred, out_dist, out_vertex});

endmodule

`default_nettype wire
